// ----- design/fsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the five-stage add/sub/lw/sw pipeline.
// Used by fsp_regfile, fsp_dmem and the top level; depends on nothing.
package fsp_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MEM_WORDS = 32;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int OFF_W     = 7;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_LW  = 2'd2,
        OP_SW  = 2'd3
    } opcode_t;

    // Decoded instruction as it sits in IF/ID and ID/EX.
    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [OFF_W-1:0]  off;
    } instr_t;

    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rt;
        logic [DATA_W-1:0] alu;
        logic [DATA_W-1:0] sdata;
    } exmem_t;

    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rt;
        logic [DATA_W-1:0] alu;
    } memwb_t;

    // Register file write port, driven from write-back.
    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] idx;
        logic [DATA_W-1:0] val;
    } wr_port_t;

    // Register 0 comes out of reset as zero, every other register as one.
    function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_AW-1:0] idx);
        logic [DATA_W-1:0] v;
        v = (idx == '0) ? '0 : DATA_W'(1);
        return v;
    endfunction

endpackage

// ----- design/fsp_regfile.sv -----
`timescale 1ns / 1ps
// Register file: one write port and two registered read ports, with per-entry
// valid bits standing in for the reset contents. Depends on fsp_pkg.
module fsp_regfile
    import fsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  wr_port_t          wr,
    input  logic [REG_AW-1:0] rd_addr_a,
    input  logic [REG_AW-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0]    regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0] written_reg;

    logic [DATA_W-1:0] q_a_reg, q_b_reg;
    logic [DATA_W-1:0] hval_a_reg, hval_b_reg;
    logic              hit_a_reg, hit_b_reg;
    logic              vld_a_reg, vld_b_reg;
    logic [REG_AW-1:0] addr_a_reg, addr_b_reg;

    always_ff @(posedge aclk) begin
        if (adv && wr.we) begin
            regs_mem[wr.idx] <= wr.val;
        end
        if (adv) begin
            q_a_reg <= regs_mem[rd_addr_a];
            q_b_reg <= regs_mem[rd_addr_b];
        end
    end

    // A write landing on the same edge as the read is passed through, so
    // the read data reflects the file after that write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
            vld_a_reg   <= 1'b0;
            vld_b_reg   <= 1'b0;
            addr_a_reg  <= '0;
            addr_b_reg  <= '0;
        end else if (adv) begin
            if (wr.we) begin
                written_reg[wr.idx] <= 1'b1;
            end
            hit_a_reg  <= wr.we && (wr.idx == rd_addr_a);
            hit_b_reg  <= wr.we && (wr.idx == rd_addr_b);
            vld_a_reg  <= written_reg[rd_addr_a];
            vld_b_reg  <= written_reg[rd_addr_b];
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hval_a_reg <= wr.val;
            hval_b_reg <= wr.val;
        end
    end

    assign rd_data_a = hit_a_reg ? hval_a_reg :
                       vld_a_reg ? q_a_reg : reg_reset_value(addr_a_reg);
    assign rd_data_b = hit_b_reg ? hval_b_reg :
                       vld_b_reg ? q_b_reg : reg_reset_value(addr_b_reg);

endmodule

// ----- design/fsp_dmem.sv -----
`timescale 1ns / 1ps
// Data memory: one address per beat, either a store or a registered load,
// with per-word valid bits so unwritten words read as one. Depends on fsp_pkg.
module fsp_dmem
    import fsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [MEM_AW-1:0] addr,
    input  logic              we,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0]    data_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] written_reg;
    logic [DATA_W-1:0]    q_reg;
    logic                 vld_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (we) begin
                data_mem[addr] <= wdata;
            end
            q_reg <= data_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            vld_reg     <= 1'b0;
        end else if (adv) begin
            if (we) begin
                written_reg[addr] <= 1'b1;
            end
            vld_reg <= written_reg[addr];
        end
    end

    assign rdata = vld_reg ? q_reg : DATA_W'(1);

endmodule

// ----- design/five_stage_pipeline_add_sub_lw_sw.sv -----
`timescale 1ns / 1ps
// Five-stage IF/ID/EX/MEM/WB pipeline for add, sub, lw and sw. Every input
// beat (an instruction or a bubble) advances all stages by one and yields
// exactly one result beat, which reports the write-back and any store done
// in that advance; it is held in an output register from the cycle after
// the input beat is taken. A new beat is taken every cycle while the result
// side keeps up, so the rate is one instruction per cycle; the pipeline stands
// still between beats. There is no interlock and no forwarding from EX/MEM:
// a write-back is seen in the same advance by EX and by MEM's store data,
// but an EX operand written by the instruction directly ahead is the old
// value. The register file is read one stage early, in ID, through its two
// registered read ports. Depends on fsp_pkg, fsp_regfile and fsp_dmem.
module five_stage_pipeline_add_sub_lw_sw
    import fsp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_instr_valid,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic [REG_AW-1:0]        s_dest_reg,
    input  logic [REG_AW-1:0]        s_src_reg,
    input  logic [REG_AW-1:0]        s_second_reg,
    input  logic [OFF_W-1:0]         s_offset,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_retire_valid,
    output logic                     m_reg_write_enable,
    output logic [REG_AW-1:0]        m_reg_write_index,
    output logic signed [DATA_W-1:0] m_reg_write_value,
    output logic                     m_mem_write_enable,
    output logic [MEM_AW-1:0]        m_mem_write_index,
    output logic signed [DATA_W-1:0] m_mem_write_value
);

    logic   accept;
    instr_t ifid_reg, idex_reg, ifid_next;
    exmem_t exmem_reg, exmem_next;
    memwb_t memwb_reg, memwb_next;

    wr_port_t          wb_wr;
    logic [DATA_W-1:0] load_data;
    logic [DATA_W-1:0] rf_a, rf_b, op_a, op_b;
    logic [MEM_AW-1:0] mem_idx;
    logic              mem_we;
    logic [DATA_W-1:0] st_data;

    logic              m_valid_reg, m_valid_next;
    logic              retire_reg, rwe_reg, mwe_reg;
    logic [REG_AW-1:0] ridx_reg;
    logic [MEM_AW-1:0] midx_reg;
    logic [DATA_W-1:0] rval_reg, mval_reg;

    // The output register frees up in the same cycle its beat is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Write-back.
    always_comb begin
        wb_wr.we  = memwb_reg.valid && (memwb_reg.op != OP_SW);
        wb_wr.idx = (memwb_reg.op == OP_LW) ? memwb_reg.rt : memwb_reg.rd;
        wb_wr.val = (memwb_reg.op == OP_LW) ? load_data : memwb_reg.alu;
    end

    // Memory access; the store data picks up a write-back of this advance.
    assign mem_idx = exmem_reg.alu[MEM_AW+1:2];
    assign mem_we  = exmem_reg.valid && (exmem_reg.op == OP_SW);
    assign st_data = (wb_wr.we && (wb_wr.idx == exmem_reg.rt)) ? wb_wr.val : exmem_reg.sdata;

    // Execute; operands read in ID are patched with this advance's write-back.
    assign op_a = (wb_wr.we && (wb_wr.idx == idex_reg.rs)) ? wb_wr.val : rf_a;
    assign op_b = (wb_wr.we && (wb_wr.idx == idex_reg.rt)) ? wb_wr.val : rf_b;

    always_comb begin
        exmem_next.valid = idex_reg.valid;
        exmem_next.op    = idex_reg.op;
        exmem_next.rd    = idex_reg.rd;
        exmem_next.rt    = idex_reg.rt;
        exmem_next.sdata = op_b;
        case (idex_reg.op)
            OP_ADD:  exmem_next.alu = op_a + op_b;
            OP_SUB:  exmem_next.alu = op_a - op_b;
            default: exmem_next.alu = op_a + DATA_W'(idex_reg.off);
        endcase
    end

    always_comb begin
        memwb_next.valid = exmem_reg.valid;
        memwb_next.op    = exmem_reg.op;
        memwb_next.rd    = exmem_reg.rd;
        memwb_next.rt    = exmem_reg.rt;
        memwb_next.alu   = exmem_reg.alu;
    end

    always_comb begin
        ifid_next.valid = s_instr_valid;
        ifid_next.op    = opcode_t'(s_opcode);
        ifid_next.rd    = s_dest_reg;
        ifid_next.rs    = s_src_reg;
        ifid_next.rt    = s_second_reg;
        ifid_next.off   = s_offset;
    end

    fsp_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (accept),
        .wr        (wb_wr),
        .rd_addr_a (ifid_reg.rs),
        .rd_addr_b (ifid_reg.rt),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    fsp_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (accept),
        .addr    (mem_idx),
        .we      (mem_we),
        .wdata   (st_data),
        .rdata   (load_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ifid_reg  <= '0;
            idex_reg  <= '0;
            exmem_reg <= '0;
            memwb_reg <= '0;
        end else if (accept) begin
            ifid_reg  <= ifid_next;
            idex_reg  <= ifid_reg;
            exmem_reg <= exmem_next;
            memwb_reg <= memwb_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result beat payload; indexes and values read as zero when not written.
    always_ff @(posedge aclk) begin
        if (accept) begin
            retire_reg <= memwb_reg.valid;
            rwe_reg    <= wb_wr.we;
            ridx_reg   <= wb_wr.we ? wb_wr.idx : '0;
            rval_reg   <= wb_wr.we ? wb_wr.val : '0;
            mwe_reg    <= mem_we;
            midx_reg   <= mem_we ? mem_idx : '0;
            mval_reg   <= mem_we ? st_data : '0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_retire_valid     = retire_reg;
    assign m_reg_write_enable = rwe_reg;
    assign m_reg_write_index  = ridx_reg;
    assign m_reg_write_value  = signed'(rval_reg);
    assign m_mem_write_enable = mwe_reg;
    assign m_mem_write_index  = midx_reg;
    assign m_mem_write_value  = signed'(mval_reg);

`ifndef ASSERT_OFF
    a_accept_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted beat did not produce a result beat");

    a_store_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && exmem_reg.valid && (exmem_reg.op == OP_SW) |=> m_mem_write_enable)
        else $error("store in MEM was not reported");

    a_no_write_without_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_retire_valid |-> !m_reg_write_enable)
        else $error("register write reported without a retiring instruction");

    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(ifid_reg) && $stable(exmem_reg) && $stable(memwb_reg))
        else $error("pipeline moved without an input beat");
`endif

endmodule

// ----- test/five_stage_pipeline_add_sub_lw_sw_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the five-stage add/sub/lw/sw pipeline: a clocked driver and monitor with
// random idle bursts on both sides, checked against an in-bench model of the pipeline.
// Depends on fsp_pkg and five_stage_pipeline_add_sub_lw_sw.
module five_stage_pipeline_add_sub_lw_sw_tb;
    import fsp_pkg::*;

    localparam int N_RANDOM   = 480;
    localparam int TAIL_ITEMS = 100;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic              instr_valid;
        opcode_t           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [OFF_W-1:0]  off;
    } fetch_t;

    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] alu;
        logic [DATA_W-1:0] load;
    } slot_t;

    typedef struct packed {
        logic              retire;
        logic              rwe;
        logic [REG_AW-1:0] ridx;
        logic [DATA_W-1:0] rval;
        logic              mwe;
        logic [MEM_AW-1:0] midx;
        logic [DATA_W-1:0] mval;
    } retire_rec_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_instr_valid = 1'b0;
    logic [OP_W-1:0]   s_opcode     = '0;
    logic [REG_AW-1:0] s_dest_reg   = '0;
    logic [REG_AW-1:0] s_src_reg    = '0;
    logic [REG_AW-1:0] s_second_reg = '0;
    logic [OFF_W-1:0]  s_offset     = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_retire_valid;
    logic m_reg_write_enable;
    logic [REG_AW-1:0] m_reg_write_index;
    logic signed [DATA_W-1:0] m_reg_write_value;
    logic m_mem_write_enable;
    logic [MEM_AW-1:0] m_mem_write_index;
    logic signed [DATA_W-1:0] m_mem_write_value;

    five_stage_pipeline_add_sub_lw_sw dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_instr_valid      (s_instr_valid),
        .s_opcode           (s_opcode),
        .s_dest_reg         (s_dest_reg),
        .s_src_reg          (s_src_reg),
        .s_second_reg       (s_second_reg),
        .s_offset           (s_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_retire_valid     (m_retire_valid),
        .m_reg_write_enable (m_reg_write_enable),
        .m_reg_write_index  (m_reg_write_index),
        .m_reg_write_value  (m_reg_write_value),
        .m_mem_write_enable (m_mem_write_enable),
        .m_mem_write_index  (m_mem_write_index),
        .m_mem_write_value  (m_mem_write_value)
    );

    always #5 aclk = ~aclk;

    fetch_t      fetch_q[$];
    retire_rec_t pending_retires[$];
    fetch_t      cur_beat;

    // Model state of the pipeline.
    logic [DATA_W-1:0] gpr [REG_COUNT];
    logic [DATA_W-1:0] dmem [MEM_WORDS];
    slot_t if_id, id_ex, ex_mem, mem_wb;

    int mismatches = 0;
    int n_results  = 0;
    int n_bubbles  = 0;
    int n_ops [4];
    int send_gap   = 0;
    int recv_stall = 0;
    int idle_cycles = 0;

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want_val);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want_val);
        mismatches++;
    endtask

    // Advance every stage once, in write-back-first order, and return what the beat reports.
    task automatic advance_pipeline(input fetch_t f, output retire_rec_t r);
        slot_t nxt;
        logic [MEM_AW-1:0] widx;
        logic [DATA_W-1:0] a, b;
        r = '0;

        if (mem_wb.valid) begin
            r.retire = 1'b1;
            if (mem_wb.op == OP_ADD || mem_wb.op == OP_SUB) begin
                gpr[mem_wb.rd] = mem_wb.alu;
                r.rwe  = 1'b1;
                r.ridx = mem_wb.rd;
                r.rval = mem_wb.alu;
            end else if (mem_wb.op == OP_LW) begin
                gpr[mem_wb.rt] = mem_wb.load;
                r.rwe  = 1'b1;
                r.ridx = mem_wb.rt;
                r.rval = mem_wb.load;
            end
        end

        nxt = ex_mem;
        nxt.load = '0;
        if (ex_mem.valid) begin
            widx = ex_mem.alu[MEM_AW+1:2];
            if (ex_mem.op == OP_LW) begin
                nxt.load = dmem[widx];
            end else if (ex_mem.op == OP_SW) begin
                // The store data is read after this beat's write-back.
                dmem[widx] = gpr[ex_mem.rt];
                r.mwe  = 1'b1;
                r.midx = widx;
                r.mval = gpr[ex_mem.rt];
            end
        end
        mem_wb = nxt;

        nxt = id_ex;
        nxt.alu  = '0;
        nxt.load = '0;
        if (id_ex.valid) begin
            a = gpr[id_ex.rs];
            b = gpr[id_ex.rt];
            case (id_ex.op)
                OP_ADD:  nxt.alu = a + b;
                OP_SUB:  nxt.alu = a - b;
                default: nxt.alu = a + DATA_W'(id_ex.off);
            endcase
        end
        ex_mem = nxt;

        id_ex = if_id;

        if_id = '0;
        if_id.valid = f.instr_valid;
        if_id.op    = f.op;
        if_id.rd    = f.rd;
        if_id.rs    = f.rs;
        if_id.rt    = f.rt;
        if_id.off   = f.off;
    endtask

    function automatic fetch_t instr(input opcode_t op, input int rd, input int rs,
                                     input int rt, input int off);
        fetch_t f;
        f.instr_valid = 1'b1;
        f.op  = op;
        f.rd  = REG_AW'(rd);
        f.rs  = REG_AW'(rs);
        f.rt  = REG_AW'(rt);
        f.off = OFF_W'(off);
        return f;
    endfunction

    always @(posedge aclk) begin : drive_proc
        retire_rec_t want;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
            for (int i = 0; i < REG_COUNT; i++) gpr[i] = (i == 0) ? '0 : DATA_W'(1);
            for (int i = 0; i < MEM_WORDS; i++) dmem[i] = DATA_W'(1);
            if_id  = '0;
            id_ex  = '0;
            ex_mem = '0;
            mem_wb = '0;
        end else begin
            if (s_valid && s_ready) begin
                advance_pipeline(cur_beat, want);
                pending_retires.push_back(want);
                if (cur_beat.instr_valid) n_ops[cur_beat.op]++;
                else n_bubbles++;
            end
            // The payload may only change once the current beat has gone.
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (fetch_q.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 7);
                    s_valid  <= 1'b0;
                end else if (fetch_q.size() != 0) begin
                    cur_beat = fetch_q.pop_front();
                    s_instr_valid <= cur_beat.instr_valid;
                    s_opcode      <= cur_beat.op;
                    s_dest_reg    <= cur_beat.rd;
                    s_src_reg     <= cur_beat.rs;
                    s_second_reg  <= cur_beat.rt;
                    s_offset      <= cur_beat.off;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : observe_proc
        retire_rec_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_retires.size() == 0) begin
                    flag_mismatch("result beat with nothing expected", '0, '0);
                end else begin
                    want = pending_retires.pop_front();
                    n_results++;
                    if (m_retire_valid !== want.retire)
                        flag_mismatch("retire_valid", DATA_W'(m_retire_valid),
                                      DATA_W'(want.retire));
                    if (m_reg_write_enable !== want.rwe)
                        flag_mismatch("reg_write_enable", DATA_W'(m_reg_write_enable),
                                      DATA_W'(want.rwe));
                    if (m_reg_write_index !== want.ridx)
                        flag_mismatch("reg_write_index", DATA_W'(m_reg_write_index),
                                      DATA_W'(want.ridx));
                    if (m_reg_write_value !== want.rval)
                        flag_mismatch("reg_write_value", m_reg_write_value, want.rval);
                    if (m_mem_write_enable !== want.mwe)
                        flag_mismatch("mem_write_enable", DATA_W'(m_mem_write_enable),
                                      DATA_W'(want.mwe));
                    if (m_mem_write_index !== want.midx)
                        flag_mismatch("mem_write_index", DATA_W'(m_mem_write_index),
                                      DATA_W'(want.midx));
                    if (m_mem_write_value !== want.mval)
                        flag_mismatch("mem_write_value", m_mem_write_value, want.mval);
                end
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else if (fetch_q.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                recv_stall <= $urandom_range(0, 7);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        fetch_t f;
        logic   narrow;

        // A bubble with every field bit set must still do nothing.
        f = instr(OP_SW, 31, 31, 31, 127);
        f.instr_valid = 1'b0;
        fetch_q.push_back(f);
        fetch_q.push_back(instr(OP_ADD, 3, 1, 2, 0));
        fetch_q.push_back(instr(OP_SUB, 4, 0, 1, 0));     // 0 - 1 wraps to all ones
        fetch_q.push_back(instr(OP_ADD, 5, 3, 3, 0));     // two behind the add to r3: sees it
        fetch_q.push_back(instr(OP_SUB, 0, 4, 0, 0));     // register zero is writable
        fetch_q.push_back(instr(OP_LW, 0, 0, 6, 0));
        fetch_q.push_back(instr(OP_SW, 0, 31, 4, 127));   // address past the end wraps the index
        fetch_q.push_back(instr(OP_SW, 0, 0, 0, 99));
        fetch_q.push_back(instr(OP_ADD, 7, 31, 31, 0));
        fetch_q.push_back(instr(OP_SW, 0, 0, 7, 4));      // store data sees the write-back ahead
        fetch_q.push_back('0);
        fetch_q.push_back(instr(OP_LW, 0, 0, 8, 4));
        fetch_q.push_back('0);
        fetch_q.push_back(instr(OP_ADD, 9, 8, 8, 0));     // two behind the load: sees its value
        fetch_q.push_back(instr(OP_SUB, 31, 31, 9, 0));
        fetch_q.push_back(instr(OP_LW, 0, 4, 0, 0));      // all-ones base wraps the address
        fetch_q.push_back(instr(OP_SW, 0, 4, 31, 127));
        fetch_q.push_back(instr(OP_ADD, 31, 31, 31, 0));
        for (int i = 0; i < 4; i++) fetch_q.push_back('0);

        // Mostly instructions on a few registers so that hazards are frequent.
        for (int i = 0; i < N_RANDOM; i++) begin
            narrow = ($urandom_range(0, 9) < 7);
            f.instr_valid = ($urandom_range(0, 99) < 85);
            f.op  = opcode_t'(OP_W'($urandom_range(0, 3)));
            f.rd  = narrow ? REG_AW'($urandom_range(0, 7)) : REG_AW'($urandom_range(0, 31));
            f.rs  = narrow ? REG_AW'($urandom_range(0, 7)) : REG_AW'($urandom_range(0, 31));
            f.rt  = narrow ? REG_AW'($urandom_range(0, 7)) : REG_AW'($urandom_range(0, 31));
            f.off = ($urandom_range(0, 3) == 0) ? OFF_W'($urandom_range(100, 127))
                                                : OFF_W'($urandom_range(0, 99));
            fetch_q.push_back(f);
        end
        // Trailing bubbles push the last instructions through write-back.
        for (int i = 0; i < 4; i++) fetch_q.push_back('0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (fetch_q.size() != 0 || s_valid) @(posedge aclk);
        while (pending_retires.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("checked %0d result beats: %0d add, %0d sub, %0d lw, %0d sw, %0d bubbles",
                 n_results, n_ops[OP_ADD], n_ops[OP_SUB], n_ops[OP_LW], n_ops[OP_SW],
                 n_bubbles);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
